// ----- hw/rtl/array_table_engine_top_defines.svh -----
// ----------------------------------------------------------------------------
// array_table_engine_top_defines
// Assertion macros used by the table engine checker. Each expects clk and
// rst to be visible at the point of use.
// ----------------------------------------------------------------------------
`ifndef ARRAY_TABLE_ENGINE_TOP_DEFINES_SVH
`define ARRAY_TABLE_ENGINE_TOP_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define ATB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define ATB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/atb_pkg.sv -----
// ----------------------------------------------------------------------------
// atb_pkg
// Widths, operation and status codes, sequencer states and the result word
// type of the value table engine.
// ----------------------------------------------------------------------------
package atb_pkg;

  localparam int unsigned OP_W         = 3;
  localparam int unsigned POS_W        = 6;
  localparam int unsigned VAL_W        = 32;
  localparam int unsigned STAT_W       = 2;
  localparam int unsigned IDX_W        = 6;
  localparam int unsigned LEN_W        = 7;
  localparam int unsigned CAPACITY_DEF = 64;

  localparam logic [OP_W-1:0] OP_SORT   = 3'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
  localparam logic [OP_W-1:0] OP_DUMP   = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_REJECTED  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_DEL_SHIFT,
    S_INS_SHIFT,
    S_INS_PUT,
    S_SORT,
    S_SORT_END,
    S_DUMP,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] entry_value;
    logic [LEN_W-1:0]        length;
    logic                    last;
  } rsp_t;

endpackage

// ----- hw/rtl/atb_ctrl.sv -----
// ----------------------------------------------------------------------------
// atb_ctrl
// Sequencer of the table engine. Streams reads through the table memory one
// entry a cycle and writes shifted or swapped entries back in the cycle after the read.
// ----------------------------------------------------------------------------
module atb_ctrl #(
  parameter int unsigned CAPACITY = atb_pkg::CAPACITY_DEF,
  localparam int unsigned AW      = $clog2(CAPACITY)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [atb_pkg::OP_W-1:0]        operation,
  input  logic [atb_pkg::POS_W-1:0]       position,
  input  logic signed [atb_pkg::VAL_W-1:0] value,
  output logic                            busy,
  output logic                            rd_en,
  output logic [AW-1:0]                   rd_addr,
  input  logic signed [atb_pkg::VAL_W-1:0] rd_data,
  output logic                            wr_en,
  output logic [AW-1:0]                   wr_addr,
  output logic signed [atb_pkg::VAL_W-1:0] wr_data,
  output logic                            rsp_vld,
  output atb_pkg::rsp_t                   rsp
);

  localparam logic [atb_pkg::LEN_W-1:0] LEN_ONE = 1;
  localparam logic [atb_pkg::LEN_W-1:0] LEN_TWO = 2;
  localparam logic [atb_pkg::LEN_W-1:0] LEN_CAP = atb_pkg::LEN_W'(CAPACITY);

  atb_pkg::state_t state, state_next;

  logic [atb_pkg::LEN_W-1:0]        count, count_next;
  logic                             pend;
  logic [atb_pkg::LEN_W-1:0]        pidx;
  logic [atb_pkg::LEN_W-1:0]        ptr;
  logic [atb_pkg::LEN_W-1:0]        pass_end;
  logic [atb_pkg::LEN_W-1:0]        pos_r;
  logic signed [atb_pkg::VAL_W-1:0] val_r;
  logic signed [atb_pkg::VAL_W-1:0] carry;
  logic                             op_del;
  logic [atb_pkg::STAT_W-1:0]       status_r;
  logic [atb_pkg::IDX_W-1:0]        index_r;

  logic                             accept;
  logic                             hit;
  logic                             at_last;
  logic                             carry_gt;
  logic [atb_pkg::LEN_W-1:0]        last_idx;
  logic [atb_pkg::LEN_W-1:0]        ptr_dec;
  logic [atb_pkg::LEN_W-1:0]        pidx_inc;
  logic [atb_pkg::LEN_W-1:0]        pidx_dec;
  logic [atb_pkg::LEN_W-1:0]        pos_ext;

  assign accept   = (state == atb_pkg::S_IDLE) && start;
  assign last_idx = count - LEN_ONE;
  assign hit      = pend && (rd_data == val_r);
  assign at_last  = pend && (pidx == last_idx);
  assign carry_gt = carry > rd_data;
  assign ptr_dec  = ptr - LEN_ONE;
  assign pidx_inc = pidx + LEN_ONE;
  assign pidx_dec = pidx - LEN_ONE;
  assign pos_ext  = {1'b0, position};

  // next state and used count
  always_comb begin
    state_next = state;
    count_next = count;
    case (state)
      atb_pkg::S_IDLE: begin
        if (start) begin
          case (operation)
            atb_pkg::OP_SORT:
              state_next = (count < LEN_TWO) ? atb_pkg::S_RESP : atb_pkg::S_SORT;
            atb_pkg::OP_SEARCH, atb_pkg::OP_DELETE:
              state_next = (count == '0) ? atb_pkg::S_RESP : atb_pkg::S_SEARCH;
            atb_pkg::OP_INSERT: begin
              if (count >= LEN_CAP || pos_ext > count) begin
                state_next = atb_pkg::S_RESP;
              end else if (pos_ext == count) begin
                state_next = atb_pkg::S_INS_PUT;
              end else begin
                state_next = atb_pkg::S_INS_SHIFT;
              end
            end
            atb_pkg::OP_DUMP:
              state_next = (count == '0) ? atb_pkg::S_RESP : atb_pkg::S_DUMP;
            default:
              state_next = atb_pkg::S_RESP;
          endcase
        end
      end
      atb_pkg::S_SEARCH: begin
        if (hit) begin
          if (op_del && !at_last) begin
            state_next = atb_pkg::S_DEL_SHIFT;
          end else begin
            state_next = atb_pkg::S_RESP;
            if (op_del) count_next = last_idx;
          end
        end else if (at_last) begin
          state_next = atb_pkg::S_RESP;
        end
      end
      atb_pkg::S_DEL_SHIFT: begin
        if (at_last) begin
          state_next = atb_pkg::S_RESP;
          count_next = last_idx;
        end
      end
      atb_pkg::S_INS_SHIFT: begin
        if (pend && pidx == pos_r) state_next = atb_pkg::S_INS_PUT;
      end
      atb_pkg::S_INS_PUT: begin
        state_next = atb_pkg::S_RESP;
        count_next = count + LEN_ONE;
      end
      atb_pkg::S_SORT: begin
        if (pend && pidx == pass_end) state_next = atb_pkg::S_SORT_END;
      end
      atb_pkg::S_SORT_END: begin
        state_next = (pass_end == LEN_ONE) ? atb_pkg::S_RESP : atb_pkg::S_SORT;
      end
      atb_pkg::S_DUMP: begin
        if (at_last) state_next = atb_pkg::S_IDLE;
      end
      atb_pkg::S_RESP: begin
        state_next = atb_pkg::S_IDLE;
      end
      default: begin
        state_next = atb_pkg::S_IDLE;
      end
    endcase
  end

  // memory requests and result word
  always_comb begin
    busy    = (state != atb_pkg::S_IDLE);
    rd_en   = 1'b0;
    rd_addr = ptr[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = pidx_dec[AW-1:0];
    wr_data = rd_data;
    rsp_vld = 1'b0;
    rsp     = '{status: status_r, index: index_r, entry_value: '0,
                length: count, last: 1'b1};
    case (state)
      atb_pkg::S_SEARCH: begin
        rd_en = (ptr < count);
      end
      atb_pkg::S_DEL_SHIFT: begin
        rd_en = (ptr < count);
        wr_en = pend;
      end
      atb_pkg::S_INS_SHIFT: begin
        rd_en   = (ptr > pos_r);
        rd_addr = ptr_dec[AW-1:0];
        wr_en   = pend;
        wr_addr = pidx_inc[AW-1:0];
      end
      atb_pkg::S_INS_PUT: begin
        wr_en   = 1'b1;
        wr_addr = pos_r[AW-1:0];
        wr_data = val_r;
      end
      atb_pkg::S_SORT: begin
        // running maximum rides in carry; the smaller of each pair goes back
        rd_en   = (ptr <= pass_end);
        wr_en   = pend && (pidx != '0);
        wr_data = carry_gt ? rd_data : carry;
      end
      atb_pkg::S_SORT_END: begin
        wr_en   = 1'b1;
        wr_addr = pass_end[AW-1:0];
        wr_data = carry;
      end
      atb_pkg::S_DUMP: begin
        rd_en   = (ptr < count);
        rsp_vld = pend;
        rsp     = '{status: atb_pkg::STAT_OK, index: pidx[atb_pkg::IDX_W-1:0],
                    entry_value: rd_data, length: count, last: at_last};
      end
      atb_pkg::S_RESP: begin
        rsp_vld = 1'b1;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= atb_pkg::S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      val_r    <= value;
      pos_r    <= pos_ext;
      op_del   <= (operation == atb_pkg::OP_DELETE);
      ptr      <= (operation == atb_pkg::OP_INSERT) ? count : '0;
      pass_end <= last_idx;
      index_r  <= '0;
      case (operation)
        atb_pkg::OP_SORT:                         status_r <= atb_pkg::STAT_OK;
        atb_pkg::OP_SEARCH, atb_pkg::OP_DELETE:   status_r <= atb_pkg::STAT_NOT_FOUND;
        atb_pkg::OP_DUMP:                         status_r <= atb_pkg::STAT_EMPTY;
        default:                                  status_r <= atb_pkg::STAT_REJECTED;
      endcase
    end

    if (rd_en) begin
      // insert walks downwards, everything else upwards
      if (state == atb_pkg::S_INS_SHIFT) begin
        ptr  <= ptr_dec;
        pidx <= ptr_dec;
      end else begin
        ptr  <= ptr + LEN_ONE;
        pidx <= ptr;
      end
    end

    case (state)
      atb_pkg::S_SEARCH: begin
        if (hit) begin
          status_r <= atb_pkg::STAT_OK;
          index_r  <= op_del ? '0 : pidx[atb_pkg::IDX_W-1:0];
        end
      end
      atb_pkg::S_INS_PUT: begin
        status_r <= atb_pkg::STAT_OK;
      end
      atb_pkg::S_SORT: begin
        if (pend && (pidx == '0 || !carry_gt)) carry <= rd_data;
      end
      atb_pkg::S_SORT_END: begin
        pass_end <= pass_end - LEN_ONE;
        ptr      <= '0;
      end
      default: begin
        carry <= carry;
      end
    endcase
  end

endmodule

// ----- hw/rtl/array_table_engine_top.sv -----
// ----------------------------------------------------------------------------
// array_table_engine_top
// Value table with a current length: sort, search, insert, delete, read-out.
// Holds the table memory and the result register around the sequencer.
// ----------------------------------------------------------------------------
//  channel   handshake                     payload
//  command   start, busy (start & !busy)   operation, position, value
//  result    strobe, one cycle per word    status, index, entry_value, length, last
//
//  One memory, one read and one write port; walks move one entry a cycle.
//  Search and delete read upwards to a match or the last entry, delete then
//  shifting the rest down; insert moves entries p..n-1 up, walking from the end;
//  sort runs bubble passes, each one shorter; read-out gives one word a cycle.
//  Reset (rst, synchronous) empties the table; old contents are never read.
//  Results cannot be stalled; busy is low by the cycle the last word shows.
// ----------------------------------------------------------------------------
module array_table_engine_top #(
  parameter int unsigned CAPACITY = atb_pkg::CAPACITY_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [atb_pkg::OP_W-1:0]         operation,
  input  logic [atb_pkg::POS_W-1:0]        position,
  input  logic signed [atb_pkg::VAL_W-1:0] value,
  output logic                             strobe,
  output logic [atb_pkg::STAT_W-1:0]       status,
  output logic [atb_pkg::IDX_W-1:0]        index,
  output logic signed [atb_pkg::VAL_W-1:0] entry_value,
  output logic [atb_pkg::LEN_W-1:0]        length,
  output logic                             last
);

  localparam int unsigned AW = $clog2(CAPACITY);

  logic signed [atb_pkg::VAL_W-1:0] mem [CAPACITY];

  logic                             rd_en;
  logic [AW-1:0]                    rd_addr;
  logic signed [atb_pkg::VAL_W-1:0] rd_data;
  logic                             wr_en;
  logic [AW-1:0]                    wr_addr;
  logic signed [atb_pkg::VAL_W-1:0] wr_data;
  logic                             rsp_vld;
  atb_pkg::rsp_t                    rsp;

  atb_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .position  (position),
    .value     (value),
    .busy      (busy),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rsp_vld   (rsp_vld),
    .rsp       (rsp)
  );

  // sequencer never reads and writes the same entry in one cycle
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= rsp_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_vld) begin
      status      <= rsp.status;
      index       <= rsp.index;
      entry_value <= rsp.entry_value;
      length      <= rsp.length;
      last        <= rsp.last;
    end
  end

endmodule

// ----- hw/rtl/atb_chk.sv -----
// ----------------------------------------------------------------------------
// atb_chk
// Port-level checks of the table engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "array_table_engine_top_defines.svh"

module atb_chk #(
  parameter int unsigned CAPACITY = atb_pkg::CAPACITY_DEF
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       strobe,
  input logic [atb_pkg::STAT_W-1:0] status,
  input logic [atb_pkg::LEN_W-1:0]  length,
  input logic                       last
);

  localparam logic [atb_pkg::LEN_W-1:0] LEN_CAP = atb_pkg::LEN_W'(CAPACITY);

  `ATB_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
  `ATB_ASSERT_SAME(a_len_cap, strobe, length <= LEN_CAP, "length beyond capacity")
  `ATB_ASSERT_NEXT(a_run_gapless, strobe && !last, strobe, "gap inside read-out run")
  `ATB_ASSERT_SAME(a_run_busy, strobe && !last, busy, "idle before read-out run ended")
  `ATB_ASSERT_SAME(a_err_last, strobe && status != atb_pkg::STAT_OK, last, "error word not last")

endmodule

bind array_table_engine_top atb_chk #(
  .CAPACITY (CAPACITY)
) u_atb_chk (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .strobe (strobe),
  .status (status),
  .length (length),
  .last   (last)
);
